FILE: rtl/core/sep_pkg.sv
`default_nettype none
package sep_pkg;

  localparam int POOL_BYTES_DEF    = 128;
  localparam int ENTROPY_BYTES_DEF = 128;
  localparam int DIGEST_BYTES      = 64;
  localparam int BLOCK_BYTES       = 128;
  localparam int ROUNDS            = 80;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic [1:0] OP_SEED  = 2'd3;

  localparam logic [511:0] CHAIN_INIT = {
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] big_sig0(input logic [63:0] x);
    big_sig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic logic [63:0] big_sig1(input logic [63:0] x);
    big_sig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic logic [63:0] sml_sig0(input logic [63:0] x);
    sml_sig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] sml_sig1(input logic [63:0] x);
    sml_sig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

  function automatic logic [63:0] round_k(input logic [6:0] t);
    case (t)
      7'd0:  round_k = 64'h428a2f98d728ae22;
      7'd1:  round_k = 64'h7137449123ef65cd;
      7'd2:  round_k = 64'hb5c0fbcfec4d3b2f;
      7'd3:  round_k = 64'he9b5dba58189dbbc;
      7'd4:  round_k = 64'h3956c25bf348b538;
      7'd5:  round_k = 64'h59f111f1b605d019;
      7'd6:  round_k = 64'h923f82a4af194f9b;
      7'd7:  round_k = 64'hab1c5ed5da6d8118;
      7'd8:  round_k = 64'hd807aa98a3030242;
      7'd9:  round_k = 64'h12835b0145706fbe;
      7'd10: round_k = 64'h243185be4ee4b28c;
      7'd11: round_k = 64'h550c7dc3d5ffb4e2;
      7'd12: round_k = 64'h72be5d74f27b896f;
      7'd13: round_k = 64'h80deb1fe3b1696b1;
      7'd14: round_k = 64'h9bdc06a725c71235;
      7'd15: round_k = 64'hc19bf174cf692694;
      7'd16: round_k = 64'he49b69c19ef14ad2;
      7'd17: round_k = 64'hefbe4786384f25e3;
      7'd18: round_k = 64'h0fc19dc68b8cd5b5;
      7'd19: round_k = 64'h240ca1cc77ac9c65;
      7'd20: round_k = 64'h2de92c6f592b0275;
      7'd21: round_k = 64'h4a7484aa6ea6e483;
      7'd22: round_k = 64'h5cb0a9dcbd41fbd4;
      7'd23: round_k = 64'h76f988da831153b5;
      7'd24: round_k = 64'h983e5152ee66dfab;
      7'd25: round_k = 64'ha831c66d2db43210;
      7'd26: round_k = 64'hb00327c898fb213f;
      7'd27: round_k = 64'hbf597fc7beef0ee4;
      7'd28: round_k = 64'hc6e00bf33da88fc2;
      7'd29: round_k = 64'hd5a79147930aa725;
      7'd30: round_k = 64'h06ca6351e003826f;
      7'd31: round_k = 64'h142929670a0e6e70;
      7'd32: round_k = 64'h27b70a8546d22ffc;
      7'd33: round_k = 64'h2e1b21385c26c926;
      7'd34: round_k = 64'h4d2c6dfc5ac42aed;
      7'd35: round_k = 64'h53380d139d95b3df;
      7'd36: round_k = 64'h650a73548baf63de;
      7'd37: round_k = 64'h766a0abb3c77b2a8;
      7'd38: round_k = 64'h81c2c92e47edaee6;
      7'd39: round_k = 64'h92722c851482353b;
      7'd40: round_k = 64'ha2bfe8a14cf10364;
      7'd41: round_k = 64'ha81a664bbc423001;
      7'd42: round_k = 64'hc24b8b70d0f89791;
      7'd43: round_k = 64'hc76c51a30654be30;
      7'd44: round_k = 64'hd192e819d6ef5218;
      7'd45: round_k = 64'hd69906245565a910;
      7'd46: round_k = 64'hf40e35855771202a;
      7'd47: round_k = 64'h106aa07032bbd1b8;
      7'd48: round_k = 64'h19a4c116b8d2d0c8;
      7'd49: round_k = 64'h1e376c085141ab53;
      7'd50: round_k = 64'h2748774cdf8eeb99;
      7'd51: round_k = 64'h34b0bcb5e19b48a8;
      7'd52: round_k = 64'h391c0cb3c5c95a63;
      7'd53: round_k = 64'h4ed8aa4ae3418acb;
      7'd54: round_k = 64'h5b9cca4f7763e373;
      7'd55: round_k = 64'h682e6ff3d6b2b8a3;
      7'd56: round_k = 64'h748f82ee5defb2fc;
      7'd57: round_k = 64'h78a5636f43172f60;
      7'd58: round_k = 64'h84c87814a1f0ab72;
      7'd59: round_k = 64'h8cc702081a6439ec;
      7'd60: round_k = 64'h90befffa23631e28;
      7'd61: round_k = 64'ha4506cebde82bde9;
      7'd62: round_k = 64'hbef9a3f7b2c67915;
      7'd63: round_k = 64'hc67178f2e372532b;
      7'd64: round_k = 64'hca273eceea26619c;
      7'd65: round_k = 64'hd186b8c721c0c207;
      7'd66: round_k = 64'heada7dd6cde0eb1e;
      7'd67: round_k = 64'hf57d4f7fee6ed178;
      7'd68: round_k = 64'h06f067aa72176fba;
      7'd69: round_k = 64'h0a637dc5a2c898a6;
      7'd70: round_k = 64'h113f9804bef90dae;
      7'd71: round_k = 64'h1b710b35131c471b;
      7'd72: round_k = 64'h28db77f523047d84;
      7'd73: round_k = 64'h32caab7b40c72493;
      7'd74: round_k = 64'h3c9ebe0a15c9bebc;
      7'd75: round_k = 64'h431d67c49c100d4c;
      7'd76: round_k = 64'h4cc5d4becb3e42b6;
      7'd77: round_k = 64'h597f299cfc657e2a;
      7'd78: round_k = 64'h5fcb6fab3ad6faec;
      7'd79: round_k = 64'h6c44198c4a475817;
      default: round_k = 64'h0;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sep_ram.sv
`default_nettype none
module sep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sha512_entropy_pool.sv
// SHA-512 entropy pool.
// Input channel in_*: one beat per operation. in_tuser carries the op (add
// entropy, read byte, flush, seed); in_tdata carries entropy/seed data and
// the entropy byte count. Output channel out_*: one beat per read op only.
// Sequential: one op at a time; in_tready is high only while idle.
// Steps per op:
//   add: accept, then write the beat's bytes into the entropy buffer in
//     turn; the byte that fills the buffer adds a hash.
//   hash: per 128-byte block, load bytes from the pool and entropy RAMs
//     (one byte-wide read port each), run 80 rounds, then update the chain;
//     absorb then writes 64 digest bytes into the pool.
//   read: when output is buffered, fetch the next byte from the output
//     buffer; on an empty output buffer the two-block hash of the pool and
//     a digest read-modify-write into the pool run first.
//   flush: an absorb when entropy is buffered; buffered output is dropped.
//   seed: a sweep of the pool RAM with the seed.
// Reset (rst_n low, synchronous) runs the same sweep with a zero seed, so
// in_tready rises once that sweep is done.
// The result sits in an output register; the block keeps accepting ops while
// it waits, and a further read holds in its last cycle until out_tready.
`default_nettype none
module sha512_entropy_pool #(
  parameter int POOL_BYTES    = sep_pkg::POOL_BYTES_DEF,
  parameter int ENTROPY_BYTES = sep_pkg::ENTROPY_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // data[63:0], size[65:64], zero [71:66]
  input  wire logic [1:0]  in_tuser,   // op[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // random_byte[7:0]
);
  import sep_pkg::*;

  localparam int PW      = (POOL_BYTES > 1) ? $clog2(POOL_BYTES) : 1;
  localparam int EAW     = (ENTROPY_BYTES > 1) ? $clog2(ENTROPY_BYTES) : 1;
  localparam int FW      = $clog2(ENTROPY_BYTES + 1);
  localparam int MSG_MAX = ((POOL_BYTES + ENTROPY_BYTES + 16) / BLOCK_BYTES + 1) * BLOCK_BYTES;
  localparam int MW      = $clog2(MSG_MAX + 1);
  localparam int BW      = MW - 7;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CLEAR   = 4'd1;
  localparam logic [3:0] S_ADD     = 4'd2;
  localparam logic [3:0] S_LOAD    = 4'd3;
  localparam logic [3:0] S_RND     = 4'd4;
  localparam logic [3:0] S_FIN     = 4'd5;
  localparam logic [3:0] S_ABS_WR  = 4'd6;
  localparam logic [3:0] S_REF_WR0 = 4'd7;
  localparam logic [3:0] S_REF_WR1 = 4'd8;
  localparam logic [3:0] S_RD_ISS  = 4'd9;
  localparam logic [3:0] S_RD_OUT  = 4'd10;

  localparam logic [1:0] SRC_POOL  = 2'd0;
  localparam logic [1:0] SRC_EBUF  = 2'd1;
  localparam logic [1:0] SRC_CONST = 2'd2;

  logic [3:0]    state_r;
  logic [PW-1:0] phase_r;
  logic [FW-1:0] free_r;
  logic [6:0]    unread_r;
  logic [63:0]   data_r;
  logic [3:0]    cnt_r;
  logic          refill_r;     // hash kind: 1 refill output, 0 absorb entropy
  logic [PW-1:0] clr_r;
  logic [7:0]    lc_r;
  logic [BW-1:0] blk_r;
  logic [6:0]    rnd_r;
  logic [6:0]    dcnt_r;
  logic [1023:0] wblk_r;
  logic [511:0]  h_r;
  logic [63:0]   v_r [8];
  logic [1:0]    src_r;
  logic [7:0]    const_r;
  logic          out_valid_r;
  logic [7:0]    out_data_r;

  // RAM ports
  logic          pool_we, ebuf_we, obuf_we, obuf_re;
  logic [PW-1:0] pool_wa, pool_ra;
  logic [7:0]    pool_wd, pool_rd, ebuf_wd, ebuf_rd, obuf_wd, obuf_rd;
  logic [EAW-1:0] ebuf_wa, ebuf_ra;
  logic [5:0]    obuf_wa, obuf_ra;

  sep_ram #(.WIDTH(8), .DEPTH(POOL_BYTES)) u_pool (
    .clk(clk), .we(pool_we), .waddr(pool_wa), .wdata(pool_wd),
    .re(1'b1), .raddr(pool_ra), .rdata(pool_rd)
  );

  sep_ram #(.WIDTH(8), .DEPTH(ENTROPY_BYTES)) u_ebuf (
    .clk(clk), .we(ebuf_we), .waddr(ebuf_wa), .wdata(ebuf_wd),
    .re(1'b1), .raddr(ebuf_ra), .rdata(ebuf_rd)
  );

  sep_ram #(.WIDTH(8), .DEPTH(DIGEST_BYTES)) u_obuf (
    .clk(clk), .we(obuf_we), .waddr(obuf_wa), .wdata(obuf_wd),
    .re(obuf_re), .raddr(obuf_ra), .rdata(obuf_rd)
  );

  logic [1:0]  in_op;
  logic [63:0] in_data;
  logic [1:0]  in_size;
  logic        in_acc;
  assign in_op     = in_tuser;
  assign in_data   = in_tdata[63:0];
  assign in_size   = in_tdata[65:64];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // message geometry
  logic [MW-1:0]   total, msg_m, eoff, len_idx, padded;
  logic [BW:0]     nblk;
  logic [63:0]     len_bits;
  logic [PW-1:0]   ph_inc, abs_base;
  logic [7:0]      dig_byte, ld_byte;
  logic [1:0]      src_nxt;
  logic [7:0]      const_nxt;

  // a refill hashes the pool alone
  assign total    = refill_r ? MW'(POOL_BYTES) :
                    MW'(POOL_BYTES) + MW'(ENTROPY_BYTES) - MW'(free_r);
  assign nblk     = (BW + 1)'(((total + MW'(16)) >> 7) + MW'(1));
  assign padded   = MW'({nblk, 7'd0});
  assign msg_m    = MW'({blk_r, lc_r[6:0]});
  assign eoff     = msg_m - MW'(POOL_BYTES);
  assign len_idx  = padded - MW'(1) - msg_m;
  assign len_bits = 64'(total) << 3;
  assign ph_inc   = (phase_r == PW'(POOL_BYTES - 1)) ? '0 : phase_r + PW'(1);
  assign abs_base = phase_r[0] ? PW'(POOL_BYTES - DIGEST_BYTES) : '0;
  assign dig_byte = h_r[511:504];
  assign ld_byte  = (src_r == SRC_POOL) ? pool_rd :
                    (src_r == SRC_EBUF) ? ebuf_rd : const_r;

  always_comb begin
    src_nxt   = SRC_CONST;
    const_nxt = 8'h00;
    if (msg_m < MW'(POOL_BYTES)) begin
      src_nxt = SRC_POOL;
    end else if (msg_m < total) begin
      src_nxt = SRC_EBUF;
    end else if (msg_m == total) begin
      const_nxt = 8'h80;
    end else if (len_idx < MW'(8)) begin
      const_nxt = 8'(len_bits >> {len_idx[2:0], 3'b000});
    end
  end

  // SHA-512 round and schedule
  logic [63:0] t1, t2, w_new;
  always_comb begin
    t1 = v_r[7] + big_sig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
       + round_k(rnd_r) + wblk_r[1023:960];
    t2 = big_sig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    w_new = wblk_r[1023:960] + sml_sig0(wblk_r[959:896]) + wblk_r[447:384]
          + sml_sig1(wblk_r[127:64]);
  end

  logic [511:0] h_sum;
  for (genvar k = 0; k < 8; k++) begin : g_fin
    assign h_sum[511-64*k -: 64] = h_r[511-64*k -: 64] + v_r[k];
  end

  // RAM port control
  always_comb begin
    pool_we = 1'b0;
    pool_wa = clr_r;
    pool_wd = 8'h00;
    pool_ra = msg_m[PW-1:0];
    ebuf_we = 1'b0;
    ebuf_wa = EAW'(free_r - FW'(1));
    ebuf_wd = data_r[7:0];
    ebuf_ra = EAW'(eoff + MW'(free_r));
    obuf_we = 1'b0;
    obuf_wa = dcnt_r[5:0];
    obuf_wd = dig_byte;
    obuf_re = 1'b0;
    obuf_ra = 6'(unread_r - 7'd1);
    case (state_r)
      S_CLEAR: begin
        pool_we = 1'b1;
        pool_wd = (clr_r < PW'(8)) ? 8'(data_r >> {clr_r[2:0], 3'b000}) : 8'h00;
      end
      S_ADD: begin
        ebuf_we = 1'b1;
      end
      S_ABS_WR: begin
        pool_we = 1'b1;
        pool_wa = abs_base + PW'(dcnt_r[5:0]);
        pool_wd = dig_byte;
      end
      S_REF_WR0: begin
        obuf_we = 1'b1;
        pool_ra = ph_inc;
      end
      S_REF_WR1: begin
        pool_we = 1'b1;
        pool_wa = phase_r;
        pool_wd = pool_rd ^ dig_byte;
      end
      S_RD_ISS: begin
        obuf_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      data_r      <= '0;
      phase_r     <= '0;
      free_r      <= FW'(ENTROPY_BYTES);
      unread_r    <= '0;
      cnt_r       <= '0;
      refill_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_RD_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            data_r <= in_data;
            case (in_op)
              OP_ADD: begin
                cnt_r   <= 4'd1 << in_size;
                state_r <= S_ADD;
              end
              OP_READ: begin
                if (unread_r == 7'd0) begin
                  refill_r <= 1'b1;
                  h_r      <= CHAIN_INIT;
                  blk_r    <= '0;
                  lc_r     <= '0;
                  state_r  <= S_LOAD;
                end else begin
                  state_r <= S_RD_ISS;
                end
              end
              OP_FLUSH: begin
                unread_r <= '0;
                cnt_r    <= '0;
                if (free_r < FW'(ENTROPY_BYTES)) begin
                  phase_r  <= ph_inc;
                  refill_r <= 1'b0;
                  h_r      <= CHAIN_INIT;
                  blk_r    <= '0;
                  lc_r     <= '0;
                  state_r  <= S_LOAD;
                end
              end
              default: begin
                clr_r    <= '0;
                phase_r  <= '0;
                free_r   <= FW'(ENTROPY_BYTES);
                unread_r <= '0;
                state_r  <= S_CLEAR;
              end
            endcase
          end
        end
        S_CLEAR: begin
          clr_r <= clr_r + PW'(1);
          if (clr_r == PW'(POOL_BYTES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_ADD: begin
          data_r <= data_r >> 8;
          cnt_r  <= cnt_r - 4'd1;
          free_r <= free_r - FW'(1);
          if (free_r == FW'(1)) begin
            // buffer full: fold it into the pool
            phase_r  <= ph_inc;
            refill_r <= 1'b0;
            h_r      <= CHAIN_INIT;
            blk_r    <= '0;
            lc_r     <= '0;
            state_r  <= S_LOAD;
          end else if (cnt_r == 4'd1) begin
            state_r <= S_IDLE;
          end
        end
        S_LOAD: begin
          // address for byte lc issued now, byte lc-1 shifted in
          src_r   <= src_nxt;
          const_r <= const_nxt;
          lc_r    <= lc_r + 8'd1;
          if (lc_r != 8'd0) begin
            wblk_r <= {wblk_r[1015:0], ld_byte};
          end
          if (lc_r == 8'(BLOCK_BYTES)) begin
            for (int k = 0; k < 8; k++) begin
              v_r[k] <= h_r[511-64*k -: 64];
            end
            rnd_r   <= '0;
            state_r <= S_RND;
          end
        end
        S_RND: begin
          v_r[0] <= t1 + t2;
          v_r[1] <= v_r[0];
          v_r[2] <= v_r[1];
          v_r[3] <= v_r[2];
          v_r[4] <= v_r[3] + t1;
          v_r[5] <= v_r[4];
          v_r[6] <= v_r[5];
          v_r[7] <= v_r[6];
          wblk_r <= {wblk_r[959:0], w_new};
          rnd_r  <= rnd_r + 7'd1;
          if (rnd_r == 7'(ROUNDS - 1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          h_r    <= h_sum;
          dcnt_r <= '0;
          if ((BW + 1)'(blk_r) + (BW + 1)'(1) < nblk) begin
            blk_r   <= blk_r + BW'(1);
            lc_r    <= '0;
            state_r <= S_LOAD;
          end else begin
            state_r <= refill_r ? S_REF_WR0 : S_ABS_WR;
          end
        end
        S_ABS_WR: begin
          h_r    <= h_r << 8;
          dcnt_r <= dcnt_r + 7'd1;
          if (dcnt_r == 7'(DIGEST_BYTES - 1)) begin
            free_r  <= FW'(ENTROPY_BYTES);
            state_r <= (cnt_r != 4'd0) ? S_ADD : S_IDLE;
          end
        end
        S_REF_WR0: begin
          phase_r <= ph_inc;
          state_r <= S_REF_WR1;
        end
        S_REF_WR1: begin
          h_r    <= h_r << 8;
          dcnt_r <= dcnt_r + 7'd1;
          if (dcnt_r == 7'(DIGEST_BYTES - 1)) begin
            unread_r <= 7'(DIGEST_BYTES);
            state_r  <= S_RD_ISS;
          end else begin
            state_r <= S_REF_WR0;
          end
        end
        S_RD_ISS: begin
          unread_r <= unread_r - 7'd1;
          state_r  <= S_RD_OUT;
        end
        S_RD_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_data_r <= obuf_rd;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> (free_r != '0) && (free_r <= FW'(ENTROPY_BYTES)))
    else $error("entropy fill count out of range while idle");

  a_unread_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD_OUT |-> unread_r < 7'(DIGEST_BYTES))
    else $error("output count not decremented on read");

  a_read_buffered: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_op == OP_READ && unread_r != 7'd0 |=> state_r == S_RD_ISS)
    else $error("buffered read did not go straight to fetch");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD || state_r == S_RND |-> !in_tready)
    else $error("input accepted during hashing");
`endif

endmodule
`default_nettype wire

FILE: bench/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sep_pkg::*;

  localparam int LIMIT = 4_000_000;
  localparam int PBYTES = 128;
  localparam int EBYTES = 128;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;

  sha512_entropy_pool i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  typedef logic [7:0] byte_q_t[$];

  logic [63:0] sha_k [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  logic [63:0] sha_iv [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  // predictor state
  logic [7:0] pool_mem [PBYTES];
  logic [7:0] ent_buf [EBYTES];
  logic [7:0] out_buf [64];
  int         ent_free;
  int         out_left;
  int         phase_ptr;

  logic [7:0] pending_bytes[$];
  int         errors;
  int         cycles;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         hold_cycles;

  function automatic logic [63:0] ror64(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [511:0] sha512_of(byte_q_t m);
    logic [63:0] h [8];
    logic [63:0] w [80];
    logic [63:0] v [8];
    logic [63:0] t1, t2, s0, s1;
    logic [511:0] dg;
    int          total, padded;
    total = m.size();
    padded = ((total + 16) / 128 + 1) * 128;
    m.push_back(8'h80);
    while (m.size() < padded - 8) m.push_back(8'h00);
    for (int i = 7; i >= 0; i--) m.push_back(8'((64'(total) * 8) >> (8 * i)));
    h = sha_iv;
    for (int blk = 0; blk < padded; blk += 128) begin
      for (int t = 0; t < 16; t++) begin
        w[t] = '0;
        for (int b = 0; b < 8; b++) w[t] = {w[t][55:0], m[blk + t * 8 + b]};
      end
      for (int t = 16; t < 80; t++) begin
        s0 = ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7);
        s1 = ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6);
        w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      v = h;
      for (int t = 0; t < 80; t++) begin
        t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_k[t] + w[t];
        t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) h[i] += v[i];
    end
    for (int i = 0; i < 8; i++) dg[511 - 64 * i -: 64] = h[i];
    return dg;
  endfunction

  function automatic void bump_phase();
    phase_ptr = (phase_ptr + 1) % PBYTES;
  endfunction

  function automatic void absorb_pool();
    byte_q_t     m;
    logic [511:0] dg;
    int          base;
    if (ent_free >= EBYTES) return;
    bump_phase();
    for (int i = 0; i < PBYTES; i++) m.push_back(pool_mem[i]);
    for (int i = ent_free; i < EBYTES; i++) m.push_back(ent_buf[i]);
    dg = sha512_of(m);
    base = phase_ptr[0] ? PBYTES - 64 : 0;
    for (int i = 0; i < 64; i++) pool_mem[base + i] = dg[511 - 8 * i -: 8];
    ent_free = EBYTES;
  endfunction

  function automatic void seed_state(logic [63:0] s);
    for (int i = 0; i < PBYTES; i++) pool_mem[i] = (i < 8) ? s[8 * i +: 8] : 8'h00;
    ent_free = EBYTES;
    out_left = 0;
    phase_ptr = 0;
  endfunction

  // returns 1 and the byte when the op yields a beat on the output
  function automatic bit predict_pool(logic [1:0] op, logic [63:0] data, logic [1:0] size,
                                      output logic [7:0] rbyte);
    byte_q_t      m;
    logic [511:0] dg;
    rbyte = '0;
    case (op)
      OP_ADD: begin
        for (int i = 0; i < (1 << size); i++) begin
          if (ent_free == 0) ent_free = EBYTES;
          ent_free--;
          ent_buf[ent_free] = data[8 * i +: 8];
          if (ent_free == 0) absorb_pool();
        end
        return 0;
      end
      OP_READ: begin
        if (out_left == 0) begin
          for (int i = 0; i < PBYTES; i++) m.push_back(pool_mem[i]);
          dg = sha512_of(m);
          for (int i = 0; i < 64; i++) begin
            out_buf[i] = dg[511 - 8 * i -: 8];
            bump_phase();
            pool_mem[phase_ptr] ^= out_buf[i];
          end
          out_left = 64;
        end
        out_left--;
        rbyte = out_buf[out_left];
        return 1;
      end
      OP_FLUSH: begin
        absorb_pool();
        out_left = 0;
        return 0;
      end
      default: begin
        seed_state(data);
        return 0;
      end
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bytes.size() == 0) begin
        $error("random_byte: unexpected beat, actual %02h", out_tdata);
        errors++;
      end else begin
        if (out_tdata !== pending_bytes[0]) begin
          $error("random_byte: expected %02h actual %02h", pending_bytes[0], out_tdata);
          errors++;
        end
        void'(pending_bytes.pop_front());
      end
    end
  end

  task automatic send_op(logic [1:0] op, logic [63:0] data, logic [1:0] size);
    logic [7:0] rbyte;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'b0, size, data};
    do @(posedge clk); while (!in_tready);
    if (predict_pool(op, data, size, rbyte)) pending_bytes.push_back(rbyte);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    send_op(OP_READ, 64'h0, 2'd0);                 // refill from an all-zero pool
    send_op(OP_READ, 64'hffff_ffff_ffff_ffff, 2'd3);
    send_op(OP_FLUSH, 64'h0, 2'd0);                // nothing buffered
    send_op(OP_ADD, 64'hffff_ffff_ffff_ffff, 2'd0); // upper bytes ignored
    send_op(OP_ADD, 64'h0, 2'd1);
    send_op(OP_ADD, 64'hffff_ffff_ffff_ffff, 2'd2);
    send_op(OP_FLUSH, rand64(), 2'd3);             // absorb a partial buffer
    send_op(OP_READ, 64'h0, 2'd0);
    send_op(OP_SEED, 64'hffff_ffff_ffff_ffff, 2'd2);
    send_op(OP_READ, 64'h0, 2'd0);
    send_op(OP_ADD, 64'h0123_4567_89ab_cdef, 2'd0);
    // 8-byte beats fill the buffer, the last one straddles the absorb
    for (int i = 0; i < 16; i++) send_op(OP_ADD, rand64(), 2'd3);
    send_op(OP_READ, 64'h0, 2'd0);
    send_op(OP_SEED, 64'h0, 2'd0);
    send_op(OP_READ, 64'h0, 2'd0);
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45)      send_op(OP_ADD, rand64(), 2'($urandom_range(3)));
      else if (r < 86) send_op(OP_READ, rand64(), 2'($urandom_range(3)));
      else if (r < 94) send_op(OP_FLUSH, rand64(), 2'($urandom_range(3)));
      else             send_op(OP_SEED, rand64(), 2'($urandom_range(3)));
    end
  endtask

  // receiver holds off while reads keep coming, so the input stalls
  task automatic test_backpressure();
    hold_cycles = 2000;
    for (int i = 0; i < 12; i++) send_op(OP_READ, rand64(), 2'd0);
    send_op(OP_ADD, rand64(), 2'd3);
    send_op(OP_READ, rand64(), 2'd0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_ADD;
    out_tready = 1'b0;
    errors = 0;
    cycles = 0;
    hold_cycles = 0;
    send_idle_pct = 35;
    recv_idle_pct = 50;
    seed_state(64'h0);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(135);
    send_idle_pct = 50;
    recv_idle_pct = 35;
    test_random(135);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(130);
    go_quiet();

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
